// ----- hw/rtl/char_bigram_counter_assert.svh -----
// Assertion macros used by the bigram counter checker.
`ifndef CHAR_BIGRAM_COUNTER_ASSERT_SVH
`define CHAR_BIGRAM_COUNTER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CBC_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("char_bigram_counter check failed");

// Check that a trigger implies a consequence, both given as sequences.
`define CBC_ASSERT_IMPL(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> cons) \
		else $error("char_bigram_counter check failed");

`endif

// ----- hw/rtl/cbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	// Operation codes of one input word
	typedef enum logic {
		OP_TRAIN = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Separator bytes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Width of the result count fields
	localparam int unsigned OUT_W = 32;

	// A word character is any byte that is not a separator
	function automatic logic is_word_char(input logic [7:0] c);
		return (c != CH_NUL) && (c != CH_SP) && (c != CH_NL) && (c != CH_CR);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cbc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on request; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/char_bigram_counter.sv -----
// Channel   Signals                                 Handshake
// input     op, char_in                             taken when start && !busy
// result    pair_count, row_total, word_end         one-cycle strobe on done
//
// An item that forms a bigram reads the count and total memories, then writes
// them back (train) or registers the result (query).
// A query result is read from the memories on the edge that takes the item,
// registered into the result registers in S_UPDATE and then shown on done.
// An ignored separator is taken without leaving S_IDLE and leaves busy low.
// After reset the block sweeps both memories to zero, one entry a cycle, over
// all 2^(2*ceil(log2(ALPHABET_SIZE))) pair entries (65536 by default), busy high.
// The result side cannot stall; the result registers hold until the next query result.
`timescale 1ns / 1ps
`default_nettype none

module char_bigram_counter #(
	parameter int unsigned COUNT_WIDTH   = 32,
	parameter int unsigned ALPHABET_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        op,
	input  wire logic [7:0]  char_in,
	output logic             busy,
	output logic             done,
	output logic [31:0]      pair_count,
	output logic [31:0]      row_total,
	output logic             word_end
);

	localparam int unsigned IDX_W = $clog2(ALPHABET_SIZE);
	localparam int unsigned CLR_W = 2 * IDX_W;
	localparam int unsigned PAIR_DEPTH = 1 << CLR_W;
	localparam int unsigned ROW_DEPTH = 1 << IDX_W;

	// Byte to table index, reduced modulo the alphabet size
	function automatic logic [2047:0] build_mod_tbl();
		logic [2047:0] tbl;
		tbl = '0;
		for (int i = 0; i < 256; i++) begin
			tbl[i*8 +: 8] = 8'(i % ALPHABET_SIZE);
		end
		return tbl;
	endfunction

	localparam logic [2047:0] MOD_TBL = build_mod_tbl();

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_UPDATE
	} state_t;

	state_t              state_q;
	logic [CLR_W-1:0]    clr_q;
	logic [7:0]          prev_q;
	cbc_pkg::op_t        op_s1;
	logic                end_s1;
	logic [CLR_W-1:0]    pair_addr_s1;
	logic [IDX_W-1:0]    row_addr_s1;
	logic                done_q;
	logic [31:0]         pair_count_q;
	logic [31:0]         row_total_q;
	logic                word_end_q;

	logic                accept;
	logic                cur_word;
	logic                prev_word;
	logic                forms_pair;
	logic [7:0]          col_char;
	logic [7:0]          next_prev;
	logic [7:0]          row_mod;
	logic [7:0]          col_mod;
	logic [IDX_W-1:0]    row_idx;
	logic [IDX_W-1:0]    col_idx;

	logic                pair_we;
	logic [CLR_W-1:0]    pair_addr;
	logic [COUNT_WIDTH-1:0] pair_wdata;
	logic [COUNT_WIDTH-1:0] pair_rd;
	logic                row_we;
	logic [IDX_W-1:0]    row_addr;
	logic [COUNT_WIDTH-1:0] row_wdata;
	logic [COUNT_WIDTH-1:0] row_rd;
	logic [COUNT_WIDTH-1:0] pair_inc;
	logic [COUNT_WIDTH-1:0] row_inc;
	logic [63:0]         pair_ext;
	logic [63:0]         row_ext;

	// Classify the incoming byte and pick the bigram it forms
	assign accept     = start && !busy;
	assign cur_word   = cbc_pkg::is_word_char(char_in);
	assign prev_word  = cbc_pkg::is_word_char(prev_q);
	assign forms_pair = cur_word || prev_word;
	assign col_char   = cur_word ? char_in : cbc_pkg::CH_NL;
	assign next_prev  = cur_word ? char_in : cbc_pkg::CH_NL;
	assign row_mod    = MOD_TBL[{prev_q, 3'b000} +: 8];
	assign col_mod    = MOD_TBL[{col_char, 3'b000} +: 8];
	assign row_idx    = IDX_W'(row_mod);
	assign col_idx    = IDX_W'(col_mod);

	// Saturating increments of the read-back counts
	assign pair_inc = (&pair_rd) ? pair_rd : pair_rd + COUNT_WIDTH'(1);
	assign row_inc  = (&row_rd) ? row_rd : row_rd + COUNT_WIDTH'(1);
	assign pair_ext = 64'(pair_rd);
	assign row_ext  = 64'(row_rd);

	// Steer the memory ports: clearing sweep, lookup or write-back
	always_comb begin
		pair_we    = 1'b0;
		pair_addr  = {row_idx, col_idx};
		pair_wdata = pair_inc;
		row_we     = 1'b0;
		row_addr   = row_idx;
		row_wdata  = row_inc;
		case (state_q)
			S_CLEAR: begin
				pair_we    = 1'b1;
				pair_addr  = clr_q;
				pair_wdata = '0;
				row_we     = (clr_q[CLR_W-1:IDX_W] == '0);
				row_addr   = clr_q[IDX_W-1:0];
				row_wdata  = '0;
			end
			S_UPDATE: begin
				pair_addr = pair_addr_s1;
				row_addr  = row_addr_s1;
				pair_we   = (op_s1 == cbc_pkg::OP_TRAIN);
				row_we    = (op_s1 == cbc_pkg::OP_TRAIN);
			end
			default: begin
			end
		endcase
	end

	cbc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.addr  (pair_addr),
		.wdata (pair_wdata),
		.rdata (pair_rd)
	);

	cbc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (ROW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.addr  (row_addr),
		.wdata (row_wdata),
		.rdata (row_rd)
	);

	// Hold state, previous character, stage registers and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			prev_q       <= cbc_pkg::CH_NL;
			op_s1        <= cbc_pkg::OP_TRAIN;
			end_s1       <= 1'b0;
			pair_addr_s1 <= '0;
			row_addr_s1  <= '0;
			done_q       <= 1'b0;
			pair_count_q <= '0;
			row_total_q  <= '0;
			word_end_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && forms_pair) begin
						op_s1        <= cbc_pkg::op_t'(op);
						end_s1       <= !cur_word;
						pair_addr_s1 <= {row_idx, col_idx};
						row_addr_s1  <= row_idx;
						prev_q       <= next_prev;
						state_q      <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (op_s1 == cbc_pkg::OP_QUERY) begin
						done_q       <= 1'b1;
						pair_count_q <= pair_ext[31:0];
						row_total_q  <= (row_ext == 64'd0) ? 32'd1 : row_ext[31:0];
						word_end_q   <= end_s1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign pair_count = pair_count_q;
	assign row_total  = row_total_q;
	assign word_end   = word_end_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cbc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "char_bigram_counter_assert.svh"

module cbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        op,
	input wire logic [7:0]  char_in,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] pair_count,
	input wire logic [31:0] row_total
);

	logic take;

	assign take = start && !busy;

	// An empty row reads as one, so a result total is never zero
	`CBC_ASSERT(a_total_nonzero, clk, arst_n, !done || (row_total != 32'd0))

	// A result only follows a cycle of work
	`CBC_ASSERT_IMPL(a_done_after_busy, clk, arst_n, done, $past(busy))

	// A training word never produces a result
	`CBC_ASSERT_IMPL(a_train_silent, clk, arst_n,
		take && (op == cbc_pkg::OP_TRAIN), ##2 !done)

	// A word character always forms a bigram and occupies the block
	`CBC_ASSERT_IMPL(a_word_busy, clk, arst_n,
		take && cbc_pkg::is_word_char(char_in), ##1 busy)

	// A bigram count never exceeds the total of its row
	`CBC_ASSERT(a_count_within_row, clk, arst_n, !done || (pair_count <= row_total))

endmodule

bind char_bigram_counter cbc_checker u_cbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.op         (op),
	.char_in    (char_in),
	.busy       (busy),
	.done       (done),
	.pair_count (pair_count),
	.row_total  (row_total)
);

`default_nettype wire

// ----- sim/tb_char_bigram_counter.sv -----
`timescale 1ns / 1ps

module tb_char_bigram_counter;

	localparam int unsigned ITEM_TARGET    = 1500;
	localparam int unsigned QUIET_LIMIT    = 300000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned DRAIN_EVERY    = 300;
	localparam logic [31:0] COUNT_SAT      = 32'hffff_ffff;

	typedef struct packed {
		logic [31:0] pair_count;
		logic [31:0] row_total;
		logic        word_end;
	} bigram_hit_t;

	typedef struct packed {
		cbc_pkg::op_t op;
		logic [7:0]   ch;
		logic         pinned;
		bigram_hit_t  hit;
	} text_row_t;

	// Directed words; rows with pinned set carry their result typed in
	localparam int unsigned N_ROWS = 24;
	localparam text_row_t TEXT_ROWS [N_ROWS] = '{
		'{cbc_pkg::OP_QUERY, 8'h61,           1'b1, '{32'd0, 32'd1, 1'b0}},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_SP,  1'b1, '{32'd0, 32'd1, 1'b1}},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_SP,  1'b0, '0},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_NUL, 1'b0, '0},
		'{cbc_pkg::OP_TRAIN, cbc_pkg::CH_CR,  1'b0, '0},
		'{cbc_pkg::OP_TRAIN, cbc_pkg::CH_NL,  1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'h61,           1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'h62,           1'b0, '0},
		'{cbc_pkg::OP_TRAIN, cbc_pkg::CH_CR,  1'b0, '0},
		'{cbc_pkg::OP_QUERY, 8'h61,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, 8'h62,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_NUL, 1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'hff,           1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'hff,           1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'h01,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_NL,  1'b1, '{32'd0, 32'd1, 1'b1}},
		'{cbc_pkg::OP_QUERY, 8'hff,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, 8'hff,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, 8'h80,           1'b0, '0},
		'{cbc_pkg::OP_TRAIN, 8'h7f,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_SP,  1'b1, '{32'd0, 32'd1, 1'b1}},
		'{cbc_pkg::OP_TRAIN, 8'h21,           1'b0, '0},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_CR,  1'b1, '{32'd0, 32'd1, 1'b1}},
		'{cbc_pkg::OP_QUERY, cbc_pkg::CH_CR,  1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = 1'b0;
	logic [7:0]  char_in = 8'h00;
	logic        busy;
	logic        done;
	logic [31:0] pair_count;
	logic [31:0] row_total;
	logic        word_end;

	// Typed-in result that travels with the word on the bus
	logic        pin_valid = 1'b0;
	bigram_hit_t pin_hit = '0;

	// Shadow of the bigram tables
	logic [7:0]  shadow_prev = cbc_pkg::CH_NL;
	logic [31:0] shadow_pairs [0:65535];
	logic [31:0] shadow_rows [0:255];

	bigram_hit_t pending_hits [$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  text_prev = cbc_pkg::CH_NL;

	char_bigram_counter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.char_in    (char_in),
		.busy       (busy),
		.done       (done),
		.pair_count (pair_count),
		.row_total  (row_total),
		.word_end   (word_end)
	);

	always #5 clk = ~clk;

	function automatic logic forms_letter(input logic [7:0] c);
		return !(c == cbc_pkg::CH_NUL || c == cbc_pkg::CH_SP ||
			c == cbc_pkg::CH_NL || c == cbc_pkg::CH_CR);
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == COUNT_SAT) ? v : v + 32'd1;
	endfunction

	// Advance the shadow tables by one byte; return 1 when a query yields a hit
	function automatic logic bigram_step(input cbc_pkg::op_t o, input logic [7:0] c,
		output bigram_hit_t hit);
		logic [7:0]  col;
		logic        closing;
		logic [15:0] idx;
		logic [31:0] tot;
		hit = '0;
		if (forms_letter(c)) begin
			col = c;
			closing = 1'b0;
		end else if (forms_letter(shadow_prev)) begin
			col = cbc_pkg::CH_NL;
			closing = 1'b1;
		end else begin
			return 1'b0;
		end
		idx = {shadow_prev, col};
		if (o == cbc_pkg::OP_TRAIN) begin
			shadow_pairs[idx] = bump(shadow_pairs[idx]);
			shadow_rows[shadow_prev] = bump(shadow_rows[shadow_prev]);
		end else begin
			tot = shadow_rows[shadow_prev];
			hit.pair_count = shadow_pairs[idx];
			hit.row_total = (tot == 32'd0) ? 32'd1 : tot;
			hit.word_end = closing;
		end
		shadow_prev = col;
		return (o == cbc_pkg::OP_QUERY);
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Check results against the oldest pending hit, then predict accepted words
	always @(posedge clk) begin : track_words
		bigram_hit_t want;
		bigram_hit_t pred;
		if (arst_n) begin
			if (done) begin
				if (pending_hits.size() == 0) begin
					note_mismatch("unexpected result, pair_count", pair_count, 32'd0);
				end else begin
					want = pending_hits.pop_front();
					if (pair_count !== want.pair_count)
						note_mismatch("pair_count", pair_count, want.pair_count);
					if (row_total !== want.row_total)
						note_mismatch("row_total", row_total, want.row_total);
					if (word_end !== want.word_end)
						note_mismatch("word_end", {31'd0, word_end}, {31'd0, want.word_end});
				end
			end
			if (start && !busy) begin
				if (bigram_step(cbc_pkg::op_t'(op), char_in, pred))
					pending_hits.push_back(pin_valid ? pin_hit : pred);
			end
		end
	end

	// Watchdog on stretches with no word taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("char_bigram_counter verification failed");
				$finish;
			end
		end
	end

	// Drive one word and hold it until taken
	task automatic send_word(input cbc_pkg::op_t o, input logic [7:0] c,
		input logic pinned, input bigram_hit_t hit);
		start <= 1'b1;
		op <= o;
		char_in <= c;
		pin_valid <= pinned;
		pin_hit <= hit;
		do @(posedge clk); while (busy);
		if (forms_letter(c))
			text_prev = c;
		else if (forms_letter(text_prev))
			text_prev = cbc_pkg::CH_NL;
	endtask

	task automatic idle_for(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and wait until every pending hit has come back
	task automatic drain_hits();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: return cbc_pkg::CH_NUL;
				1: return cbc_pkg::CH_NL;
				2: return cbc_pkg::CH_CR;
				default: return cbc_pkg::CH_SP;
			endcase
		end
		if (r < 16)
			return cbc_pkg::CH_SP;
		if (r < 30)
			return 8'($urandom_range(0, 255));
		return 8'h61 + 8'($urandom_range(0, 5));
	endfunction

	initial begin : stimulus
		int unsigned  counted;
		int unsigned  burst;
		int unsigned  query_pct;
		int unsigned  since_drain;
		logic [7:0]   c;
		cbc_pkg::op_t o;
		logic         counts;
		for (int i = 0; i < 65536; i++)
			shadow_pairs[i] = '0;
		for (int i = 0; i < 256; i++)
			shadow_rows[i] = '0;

		// Hold reset, then release on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < N_ROWS; i++) begin
			send_word(TEXT_ROWS[i].op, TEXT_ROWS[i].ch, TEXT_ROWS[i].pinned,
				TEXT_ROWS[i].hit);
			if (i % 5 == 4)
				idle_for($urandom_range(1, 3));
		end
		drain_hits();

		// Random text in bursts; each burst leans toward train or query
		counted = 0;
		since_drain = 0;
		while (counted < ITEM_TARGET) begin
			burst = $urandom_range(1, 24);
			query_pct = $urandom_range(0, 3) * 25;
			repeat (burst) begin
				c = pick_text_byte();
				o = ($urandom_range(0, 99) < query_pct) ? cbc_pkg::OP_QUERY
					: cbc_pkg::OP_TRAIN;
				counts = forms_letter(c) || forms_letter(text_prev);
				send_word(o, c, 1'b0, '0);
				if (counts) begin
					counted++;
					since_drain++;
				end
			end
			if (since_drain >= DRAIN_EVERY) begin
				drain_hits();
				since_drain = 0;
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 9));
			end
		end

		// Let the last results land, then report
		drain_hits();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("char_bigram_counter verification clean");
		else
			$display("char_bigram_counter verification failed");
		$finish;
	end

endmodule
